// File: design/cabc_pkg.sv
// Shared types, constants and helper functions of the chained additive byte cipher.
package cabc_pkg;

  // Field and register widths
  localparam int DATA_W     = 8;
  localparam int KEY_W      = 64;
  localparam int KEY_LEN_W  = 4;
  localparam int BLK_LEN_W  = 8;
  localparam int KEY_IDX_W  = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = KEY_W;

  localparam int MAX_KEY_LEN = 8;

  // Reset values of the configuration registers
  localparam logic [KEY_W-1:0]     KEY_RESET       = 64'h424C_4738_3637_3233;
  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET   = 4'd8;
  localparam logic [BLK_LEN_W-1:0] BLOCK_LEN_RESET = 8'd28;

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_BYTES    = 3'd0,
    CFG_KEY_LENGTH   = 3'd1,
    CFG_BLOCK_LENGTH = 3'd2,
    CFG_ENCRYPT_MODE = 3'd3
  } cfg_index_t;

  // Configuration as seen by the cipher engine
  typedef struct packed {
    logic [KEY_W-1:0]     key_bytes;
    logic [KEY_LEN_W-1:0] key_len;     // already clamped to 1..MAX_KEY_LEN
    logic [BLK_LEN_W-1:0] block_length;
    logic                 encrypt_mode;
    logic                 reseed;      // one-cycle pulse on any listed write
  } cabc_cfg_t;

  // Clamp the raw key length into the range 1..MAX_KEY_LEN.
  function automatic logic [KEY_LEN_W-1:0] eff_key_len(input logic [KEY_LEN_W-1:0] raw);
    logic [KEY_LEN_W-1:0] n;
    n = raw;
    if (n == '0) n = KEY_LEN_W'(1);
    if (n > KEY_LEN_W'(MAX_KEY_LEN)) n = KEY_LEN_W'(MAX_KEY_LEN);
    return n;
  endfunction

  // Starting key position of a block: 25 modulo the key length.
  function automatic logic [KEY_IDX_W-1:0] seed_index(input logic [KEY_LEN_W-1:0] len);
    logic [KEY_IDX_W-1:0] idx;
    case (len)
      4'd2:    idx = 3'd1;
      4'd3:    idx = 3'd1;
      4'd4:    idx = 3'd1;
      4'd6:    idx = 3'd1;
      4'd7:    idx = 3'd4;
      4'd8:    idx = 3'd1;
      default: idx = 3'd0;
    endcase
    return idx;
  endfunction

  // Key byte n sits in bits 8n+7 down to 8n.
  function automatic logic [DATA_W-1:0] key_byte(input logic [KEY_W-1:0] key,
                                                  input logic [KEY_IDX_W-1:0] idx);
    return key[idx*DATA_W +: DATA_W];
  endfunction

endpackage

// File: design/cabc_if.sv
// Valid/ready channel interfaces for the input and result bytes.
interface cabc_in_if;
  import cabc_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_in;

  modport source (output valid, output data_in, input ready);
  modport sink (input valid, input data_in, output ready);
endinterface

interface cabc_out_if;
  import cabc_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_out;

  modport source (output valid, output data_out, input ready);
  modport sink (input valid, input data_out, output ready);
endinterface

// File: design/chained_additive_byte_cipher_core.sv
// Top level of the chained additive byte cipher: configuration, engine and result register.
//
//   Channel   Direction  Payload              Handshake
//   in_ch     sink       data_in  (8 bits)    valid/ready
//   out_ch    source     data_out (8 bits)    valid/ready
//   cfg_*     sink       index 3b, data 64b   write enable only
//
// One byte is accepted per cycle while the result register is empty or being emptied;
// its result appears in the result register on the next cycle. Reset (synchronous,
// rst_n low) restores the register defaults and re-seeds the cipher; there is no
// clearing pass. Input is taken whenever the result register is empty or is being
// emptied in the same cycle.
module chained_additive_byte_cipher_core
  import cabc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  cabc_in_if.sink               in_ch,
  cabc_out_if.source            out_ch,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cabc_cfg_t         cfg;
  logic              accept;
  logic [DATA_W-1:0] result;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_data_r;

  cabc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Input handshake.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  cabc_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .step     (accept),
    .data_in  (in_ch.data_in),
    .data_out (result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= result;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.data_out = out_data_r;

endmodule

// File: design/cabc_cfg_regs.sv
// Configuration registers and the re-seed request raised by every listed write.
module cabc_cfg_regs
  import cabc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cabc_cfg_t             cfg
);

  logic [KEY_W-1:0]     key_bytes_r;
  logic [KEY_LEN_W-1:0] key_length_r;
  logic [BLK_LEN_W-1:0] block_length_r;
  logic                 encrypt_mode_r;
  logic                 listed;

  // A write to an index beyond the list is ignored altogether.
  always_comb begin
    case (cfg_index)
      CFG_KEY_BYTES,
      CFG_KEY_LENGTH,
      CFG_BLOCK_LENGTH,
      CFG_ENCRYPT_MODE: listed = 1'b1;
      default:          listed = 1'b0;
    endcase
  end

  // Register file update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_bytes_r    <= KEY_RESET;
      key_length_r   <= KEY_LEN_RESET;
      block_length_r <= BLOCK_LEN_RESET;
      encrypt_mode_r <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_KEY_BYTES:    key_bytes_r    <= cfg_wdata;
        CFG_KEY_LENGTH:   key_length_r   <= cfg_wdata[KEY_LEN_W-1:0];
        CFG_BLOCK_LENGTH: block_length_r <= cfg_wdata[BLK_LEN_W-1:0];
        CFG_ENCRYPT_MODE: encrypt_mode_r <= cfg_wdata[0];
        default:          ;
      endcase
    end
  end

  // Present the configuration with the key length already clamped.
  assign cfg.key_bytes    = key_bytes_r;
  assign cfg.key_len      = eff_key_len(key_length_r);
  assign cfg.block_length = block_length_r;
  assign cfg.encrypt_mode = encrypt_mode_r;
  assign cfg.reseed       = cfg_wr_en && listed;

endmodule

// File: design/cabc_engine.sv
// Cipher state (key position, chaining byte, block position) and the byte transform.
module cabc_engine
  import cabc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cabc_cfg_t         cfg,
  input  logic              step,
  input  logic [DATA_W-1:0] data_in,
  output logic [DATA_W-1:0] data_out
);

  logic [KEY_IDX_W-1:0] key_index_r, key_index_nxt;
  logic [DATA_W-1:0]    chain_r, chain_nxt;
  logic [BLK_LEN_W-1:0] pos_r, pos_nxt;
  logic                 pend_r;     // re-seed owed after reset or a configuration write

  logic                 reseed_now;
  logic [KEY_IDX_W-1:0] seed_idx;
  logic [KEY_IDX_W-1:0] idx;
  logic [DATA_W-1:0]    chain_cur;
  logic [DATA_W-1:0]    key_cur;
  logic [KEY_LEN_W-1:0] idx_inc;
  logic [BLK_LEN_W:0]   pos_inc;

  // Re-seed at the head of each block when the block length is nonzero, or once after reset or a configuration change.
  assign reseed_now = pend_r || ((cfg.block_length != '0) && (pos_r == '0));
  assign seed_idx   = seed_index(cfg.key_len);
  assign idx        = reseed_now ? seed_idx : key_index_r;
  assign chain_cur  = reseed_now ? key_byte(cfg.key_bytes, seed_idx) : chain_r;
  assign key_cur    = key_byte(cfg.key_bytes, idx);

  // Transform and the next chaining byte.
  always_comb begin
    if (cfg.encrypt_mode) begin
      data_out  = data_in + chain_cur + key_cur;
      chain_nxt = data_out;
    end else begin
      data_out  = data_in - chain_cur - key_cur;
      chain_nxt = data_in;
    end
  end

  // Key position wraps over the key bytes in use; block position wraps at the block length.
  always_comb begin
    idx_inc       = {1'b0, idx} + KEY_LEN_W'(1);
    key_index_nxt = (idx_inc >= cfg.key_len) ? '0 : idx_inc[KEY_IDX_W-1:0];
    pos_inc       = {1'b0, pos_r} + (BLK_LEN_W+1)'(1);
    if (cfg.block_length == '0) begin
      pos_nxt = '0;
    end else if (pos_inc >= {1'b0, cfg.block_length}) begin
      pos_nxt = '0;
    end else begin
      pos_nxt = pos_inc[BLK_LEN_W-1:0];
    end
  end

  // Control state: pending re-seed flag and block position.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b1;
      pos_r  <= '0;
    end else if (cfg.reseed) begin
      pend_r <= 1'b1;
      pos_r  <= '0;
    end else if (step) begin
      pend_r <= 1'b0;
      pos_r  <= pos_nxt;
    end
  end

  // Key position and chaining byte are only read once the pending flag has been served.
  always_ff @(posedge clk) begin
    if (step) begin
      key_index_r <= key_index_nxt;
      chain_r     <= chain_nxt;
    end
  end

endmodule
